FILE: rtl/dual_vacuum_filter_with_command_reply_assert.svh
// Assertion macros for the vacuum filter block.
// Each macro expects clk and rst_n in scope.
`ifndef DUAL_VACUUM_FILTER_WITH_COMMAND_REPLY_ASSERT_SVH
`define DUAL_VACUUM_FILTER_WITH_COMMAND_REPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DVF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DVF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dvf_pkg.sv
package dvf_pkg;

  localparam int GAIN_BITS  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CHAR_BITS  = 7;
  localparam int PREFIX_LEN = 4;
  localparam int WORD_BITS  = CHAR_BITS * PREFIX_LEN;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd9830;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_GAIN = 2'd0,
    CFG_OFFSET_A    = 2'd1,
    CFG_OFFSET_B    = 2'd2,
    CFG_UNUSED      = 2'd3
  } dvf_cfg_idx_t;

  typedef enum logic [2:0] {
    RPL_IDENTIFY = 3'd0,
    RPL_VACUUM   = 3'd1,
    RPL_ZEROED   = 3'd2,
    RPL_SAVE     = 3'd3,
    RPL_RESET    = 3'd4,
    RPL_OK       = 3'd5
  } dvf_reply_t;

  localparam logic [7:0] CHR_LF    = 8'd10;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_TILDE = 8'd126;
  localparam logic [7:0] CHR_LOW_A = 8'd97;
  localparam logic [7:0] CHR_LOW_Z = 8'd122;
  localparam logic [CHAR_BITS-1:0] CASE_BIT = 7'h20;

  typedef logic [PREFIX_LEN-1:0][CHAR_BITS-1:0] dvf_prefix_t;

  function automatic logic [WORD_BITS-1:0] word4(input logic [7:0] c0, input logic [7:0] c1,
                                                 input logic [7:0] c2, input logic [7:0] c3);
    return {c3[CHAR_BITS-1:0], c2[CHAR_BITS-1:0], c1[CHAR_BITS-1:0], c0[CHAR_BITS-1:0]};
  endfunction

  localparam logic [WORD_BITS-1:0] CMD_M115 = word4("M", "1", "1", "5");
  localparam logic [WORD_BITS-1:0] CMD_M800 = word4("M", "8", "0", "0");
  localparam logic [WORD_BITS-1:0] CMD_M105 = word4("M", "1", "0", "5");
  localparam logic [WORD_BITS-1:0] CMD_M802 = word4("M", "8", "0", "2");
  localparam logic [WORD_BITS-1:0] CMD_M500 = word4("M", "5", "0", "0");
  localparam logic [WORD_BITS-1:0] CMD_M502 = word4("M", "5", "0", "2");

endpackage

FILE: rtl/dvf_in_if.sv
interface dvf_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic                   channel;
  logic [SAMPLE_BITS-1:0] sample;
  logic [7:0]             text_byte;

  modport source (output valid, kind, channel, sample, text_byte, input ready);
  modport sink   (input valid, kind, channel, sample, text_byte, output ready);
endinterface

FILE: rtl/dvf_out_if.sv
interface dvf_out_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             reply;
  logic [SAMPLE_BITS:0]   vacuum_a;
  logic [SAMPLE_BITS:0]   vacuum_b;
  logic [SAMPLE_BITS-1:0] offset_a_out;
  logic [SAMPLE_BITS-1:0] offset_b_out;

  modport source (output valid, reply, vacuum_a, vacuum_b, offset_a_out, offset_b_out,
                  input ready);
  modport sink   (input valid, reply, vacuum_a, vacuum_b, offset_a_out, offset_b_out,
                  output ready);
endinterface

FILE: rtl/dual_vacuum_filter_with_command_reply.sv
// Two-channel vacuum filter with a serial command decoder. Each transfer on
// in_ch is either an ADC sample, which moves that channel's Q(SAMPLE_BITS).
// (FRACTION_BITS) level toward it by level += gain*(sample-level) (floored),
// or a command byte; a CR or LF closing a nonempty line yields one reply on
// out_ch. An item is taken into an input register and handled from there by
// one multiply-add or one character compare against the state, so a new item
// can be taken every cycle; the sustained rate is one item per cycle while
// out_ch takes replies. A reply is loaded into the result register when its
// line's CR or LF leaves the input register, and is held there until taken;
// while a reply waits, the input register holds its item, and input stalls
// once that register is occupied. Configuration writes take effect at once;
// writing an initial offset reloads that channel's tare and level.
`include "dual_vacuum_filter_with_command_reply_assert.svh"

module dual_vacuum_filter_with_command_reply
  import dvf_pkg::*;
#(
  parameter int SAMPLE_BITS   = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dvf_in_if.sink                in_ch,
  dvf_out_if.source             out_ch
);

  localparam int LW = SAMPLE_BITS + FRACTION_BITS;
  localparam int PW = LW + GAIN_BITS + 2;
  localparam int CW = $clog2(PREFIX_LEN + 1);

  logic                   s1_valid_r;
  logic                   s1_kind_r;
  logic                   s1_channel_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [7:0]             s1_byte_r;

  logic [GAIN_BITS-1:0]   gain_r;
  logic [LW-1:0]          level_a_r, level_a_nxt;
  logic [LW-1:0]          level_b_r, level_b_nxt;
  logic [SAMPLE_BITS-1:0] tare_a_r, tare_a_nxt;
  logic [SAMPLE_BITS-1:0] tare_b_r, tare_b_nxt;
  dvf_prefix_t            prefix_r, prefix_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   has_text_r, has_text_nxt;

  logic                   out_valid_r;
  dvf_reply_t             reply_r, reply_nxt;
  logic [SAMPLE_BITS:0]   vac_a_r, vac_a_nxt;
  logic [SAMPLE_BITS:0]   vac_b_r, vac_b_nxt;
  logic [SAMPLE_BITS-1:0] ofs_a_r, ofs_a_nxt;
  logic [SAMPLE_BITS-1:0] ofs_b_r, ofs_b_nxt;
  logic                   res_nxt;

  logic                   advance;
  logic [LW-1:0]          sel_level;
  logic signed [LW:0]     diff;
  logic signed [PW-1:0]   prod;
  logic [LW-1:0]          ema_level;
  logic signed [SAMPLE_BITS:0] va_diff, vb_diff;
  logic [CHAR_BITS-1:0]   chr;
  logic [WORD_BITS-1:0]   word;
  logic                   full;
  logic                   is_eol, is_print;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r    <= in_ch.kind;
      s1_channel_r <= in_ch.channel;
      s1_sample_r  <= in_ch.sample;
      s1_byte_r    <= in_ch.text_byte;
    end
  end

  assign sel_level = s1_channel_r ? level_b_r : level_a_r;
  assign diff      = $signed({1'b0, s1_sample_r, {FRACTION_BITS{1'b0}}})
                   - $signed({1'b0, sel_level});
  assign prod      = diff * $signed({1'b0, gain_r});
  assign ema_level = sel_level + prod[GAIN_BITS +: LW];

  assign va_diff = $signed({1'b0, tare_a_r}) - $signed({1'b0, level_a_r[LW-1:FRACTION_BITS]});
  assign vb_diff = $signed({1'b0, tare_b_r}) - $signed({1'b0, level_b_r[LW-1:FRACTION_BITS]});

  assign word     = prefix_r;
  assign full     = (cnt_r == CW'(PREFIX_LEN));
  assign is_eol   = (s1_byte_r == CHR_LF) || (s1_byte_r == CHR_CR);
  assign is_print = (s1_byte_r >= CHR_SPACE) && (s1_byte_r <= CHR_TILDE);

  always_comb begin
    chr = s1_byte_r[CHAR_BITS-1:0];
    if (s1_byte_r >= CHR_LOW_A && s1_byte_r <= CHR_LOW_Z) begin
      chr = chr & ~CASE_BIT;
    end
  end

  always_comb begin
    level_a_nxt  = level_a_r;
    level_b_nxt  = level_b_r;
    tare_a_nxt   = tare_a_r;
    tare_b_nxt   = tare_b_r;
    prefix_nxt   = prefix_r;
    cnt_nxt      = cnt_r;
    has_text_nxt = has_text_r;
    res_nxt      = 1'b0;
    reply_nxt    = RPL_OK;
    vac_a_nxt    = '0;
    vac_b_nxt    = '0;
    ofs_a_nxt    = '0;
    ofs_b_nxt    = '0;

    if (advance) begin
      if (!s1_kind_r) begin
        if (s1_channel_r) begin
          level_b_nxt = ema_level;
        end else begin
          level_a_nxt = ema_level;
        end
      end else if (is_eol) begin
        prefix_nxt   = '0;
        cnt_nxt      = '0;
        has_text_nxt = 1'b0;
        res_nxt      = has_text_r;
        if (has_text_r && full) begin
          priority if (word == CMD_M115) begin
            reply_nxt = RPL_IDENTIFY;
          end else if (word == CMD_M800 || word == CMD_M105) begin
            reply_nxt = RPL_VACUUM;
            vac_a_nxt = va_diff[SAMPLE_BITS] ? '0 : va_diff;
            vac_b_nxt = vb_diff[SAMPLE_BITS] ? '0 : vb_diff;
          end else if (word == CMD_M802) begin
            reply_nxt  = RPL_ZEROED;
            tare_a_nxt = level_a_r[LW-1:FRACTION_BITS];
            tare_b_nxt = level_b_r[LW-1:FRACTION_BITS];
          end else if (word == CMD_M500) begin
            reply_nxt = RPL_SAVE;
            ofs_a_nxt = tare_a_r;
            ofs_b_nxt = tare_b_r;
          end else if (word == CMD_M502) begin
            reply_nxt = RPL_RESET;
          end else begin
            reply_nxt = RPL_OK;
          end
        end
      end else if (is_print && !(s1_byte_r == CHR_SPACE && !has_text_r)) begin
        has_text_nxt = 1'b1;
        if (!full) begin
          prefix_nxt[cnt_r[CW-2:0]] = chr;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end

    if (cfg_we) begin
      unique case (dvf_cfg_idx_t'(cfg_index))
        CFG_OFFSET_A: begin
          tare_a_nxt  = cfg_data[SAMPLE_BITS-1:0];
          level_a_nxt = {cfg_data[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}};
        end
        CFG_OFFSET_B: begin
          tare_b_nxt  = cfg_data[SAMPLE_BITS-1:0];
          level_b_nxt = {cfg_data[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}};
        end
        CFG_FILTER_GAIN, CFG_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RESET;
      level_a_r  <= '0;
      level_b_r  <= '0;
      tare_a_r   <= '0;
      tare_b_r   <= '0;
      prefix_r   <= '0;
      cnt_r      <= '0;
      has_text_r <= 1'b0;
    end else begin
      if (cfg_we && dvf_cfg_idx_t'(cfg_index) == CFG_FILTER_GAIN) begin
        gain_r <= cfg_data[GAIN_BITS-1:0];
      end
      level_a_r  <= level_a_nxt;
      level_b_r  <= level_b_nxt;
      tare_a_r   <= tare_a_nxt;
      tare_b_r   <= tare_b_nxt;
      prefix_r   <= prefix_nxt;
      cnt_r      <= cnt_nxt;
      has_text_r <= has_text_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_nxt) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_nxt) begin
      reply_r <= reply_nxt;
      vac_a_r <= vac_a_nxt;
      vac_b_r <= vac_b_nxt;
      ofs_a_r <= ofs_a_nxt;
      ofs_b_r <= ofs_b_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.reply        = reply_r;
  assign out_ch.vacuum_a     = vac_a_r;
  assign out_ch.vacuum_b     = vac_b_r;
  assign out_ch.offset_a_out = ofs_a_r;
  assign out_ch.offset_b_out = ofs_b_r;

  `DVF_ASSERT_NOW(a_vac_only_on_data, out_valid_r && reply_r != RPL_VACUUM,
                  vac_a_r == '0 && vac_b_r == '0, "vacuum value on non-data reply")
  `DVF_ASSERT_NOW(a_ofs_only_on_save, out_valid_r && reply_r != RPL_SAVE,
                  ofs_a_r == '0 && ofs_b_r == '0, "offset value on non-save reply")
  `DVF_ASSERT_NOW(a_prefix_bound, 1'b1, cnt_r <= CW'(PREFIX_LEN),
                  "prefix count beyond four characters")
  `DVF_ASSERT_NEXT(a_stage_hold, s1_valid_r && !advance, s1_valid_r,
                   "stalled input stage lost its item")

endmodule

FILE: test/tb_dual_vacuum_filter_with_command_reply.sv
import dvf_pkg::*;

localparam logic KIND_SAMPLE = 1'b0;
localparam logic KIND_TEXT   = 1'b1;
localparam logic CHAN_A      = 1'b0;
localparam logic CHAN_B      = 1'b1;
localparam int   FRAC_BITS   = 16;
localparam int   VAC_CLAMP   = 1024;

typedef struct packed {
  dvf_reply_t  reply;
  logic [10:0] vac_a;
  logic [10:0] vac_b;
  logic [9:0]  off_a;
  logic [9:0]  off_b;
} vacuum_reply_t;

class vacuum_reply_scoreboard;
  logic [15:0]           gain;
  logic [9:0]            tare_a;
  logic [9:0]            tare_b;
  longint                level_a;
  longint                level_b;
  logic [WORD_BITS-1:0]  line_word;
  int                    word_len;
  bit                    line_has_text;
  vacuum_reply_t         pending_replies[$];
  int                    errors;

  function new();
    gain          = GAIN_RESET;
    tare_a        = '0;
    tare_b        = '0;
    level_a       = 0;
    level_b       = 0;
    line_word     = '0;
    word_len      = 0;
    line_has_text = 1'b0;
    errors        = 0;
  endfunction

  function void write_reg(dvf_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FILTER_GAIN: gain = data;
      CFG_OFFSET_A: begin
        tare_a  = data[9:0];
        level_a = longint'(tare_a) <<< FRAC_BITS;
      end
      CFG_OFFSET_B: begin
        tare_b  = data[9:0];
        level_b = longint'(tare_b) <<< FRAC_BITS;
      end
      default: ;
    endcase
  endfunction

  function longint smooth_level(longint lvl, logic [9:0] smp);
    longint diff;
    longint prod;
    diff = (longint'(smp) <<< FRAC_BITS) - lvl;
    prod = diff * longint'(gain);
    return lvl + (prod >>> GAIN_BITS);
  endfunction

  function logic [10:0] clamped_vacuum(logic [9:0] tare, longint lvl);
    longint v;
    v = longint'(tare) - (lvl >>> FRAC_BITS);
    if (v < 0) v = 0;
    if (v > VAC_CLAMP) v = VAC_CLAMP;
    return 11'(v);
  endfunction

  function void take_item(logic kind, logic chan, logic [9:0] smp, logic [7:0] txt);
    vacuum_reply_t r;
    logic [CHAR_BITS-1:0] c7;
    bit full;
    if (kind == KIND_SAMPLE) begin
      if (chan == CHAN_A) level_a = smooth_level(level_a, smp);
      else level_b = smooth_level(level_b, smp);
    end else if (txt == CHR_LF || txt == CHR_CR) begin
      if (line_has_text) begin
        full = (word_len == PREFIX_LEN);
        r = '0;
        r.reply = RPL_OK;
        if (full && line_word == CMD_M115) begin
          r.reply = RPL_IDENTIFY;
        end else if (full && (line_word == CMD_M800 || line_word == CMD_M105)) begin
          r.reply = RPL_VACUUM;
          r.vac_a = clamped_vacuum(tare_a, level_a);
          r.vac_b = clamped_vacuum(tare_b, level_b);
        end else if (full && line_word == CMD_M802) begin
          r.reply = RPL_ZEROED;
          tare_a  = 10'(level_a >>> FRAC_BITS);
          tare_b  = 10'(level_b >>> FRAC_BITS);
        end else if (full && line_word == CMD_M500) begin
          r.reply = RPL_SAVE;
          r.off_a = tare_a;
          r.off_b = tare_b;
        end else if (full && line_word == CMD_M502) begin
          r.reply = RPL_RESET;
        end
        pending_replies.push_back(r);
      end
      line_word     = '0;
      word_len      = 0;
      line_has_text = 1'b0;
    end else if (txt >= CHR_SPACE && txt <= CHR_TILDE &&
                 !(txt == CHR_SPACE && !line_has_text)) begin
      line_has_text = 1'b1;
      if (word_len < PREFIX_LEN) begin
        c7 = txt[CHAR_BITS-1:0];
        if (txt >= CHR_LOW_A && txt <= CHR_LOW_Z) c7 = c7 & ~CASE_BIT;
        line_word[CHAR_BITS*word_len +: CHAR_BITS] = c7;
        word_len++;
      end
    end
  endfunction

  task report(string what);
    $display("error at %0t: %s", $time, what);
    errors++;
  endtask

  task check_reply(logic [2:0] reply, logic [10:0] va, logic [10:0] vb,
                   logic [9:0] oa, logic [9:0] ob);
    vacuum_reply_t exp;
    if (pending_replies.size() == 0) begin
      report($sformatf("reply %0d with none expected", reply));
      return;
    end
    exp = pending_replies.pop_front();
    if (reply !== exp.reply)
      report($sformatf("reply %0d, expected %0d", reply, exp.reply));
    if (va !== exp.vac_a)
      report($sformatf("vacuum_a %0d, expected %0d", va, exp.vac_a));
    if (vb !== exp.vac_b)
      report($sformatf("vacuum_b %0d, expected %0d", vb, exp.vac_b));
    if (oa !== exp.off_a)
      report($sformatf("offset_a_out %0d, expected %0d", oa, exp.off_a));
    if (ob !== exp.off_b)
      report($sformatf("offset_b_out %0d, expected %0d", ob, exp.off_b));
  endtask
endclass

module tb_dual_vacuum_filter_with_command_reply;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  dvf_cfg_idx_t          cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dvf_in_if  #(.SAMPLE_BITS(10)) in_ch ();
  dvf_out_if #(.SAMPLE_BITS(10)) out_ch ();

  vacuum_reply_scoreboard sb = new();

  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    hold_left     = 0;
  bit    start_hold    = 1'b0;
  int    items_sent    = 0;
  string command_words[6] = '{"M115", "M800", "M105", "M802", "M500", "M502"};

  dual_vacuum_filter_with_command_reply #(
    .SAMPLE_BITS  (10),
    .FRACTION_BITS(16)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.take_item(in_ch.kind, in_ch.channel, in_ch.sample, in_ch.text_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_reply(out_ch.reply, out_ch.vacuum_a, out_ch.vacuum_b,
                       out_ch.offset_a_out, out_ch.offset_b_out);
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (start_hold) begin
        hold_left  = 400;
        start_hold = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] printable_byte();
    return 8'($urandom_range(126, 32));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= CHR_SPACE && b <= CHR_TILDE) || b == CHR_CR || b == CHR_LF);
    return b;
  endfunction

  function automatic logic [9:0] random_sample();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 10'd1023 : 10'd0;
    return 10'($urandom_range(1023));
  endfunction

  task automatic send_item(logic kind, logic chan, logic [9:0] smp, logic [7:0] txt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.channel   <= chan;
    in_ch.sample    <= smp;
    in_ch.text_byte <= txt;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_sample(logic chan, logic [9:0] smp);
    send_item(KIND_SAMPLE, chan, smp, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] txt);
    send_item(KIND_TEXT, 1'($urandom), 10'($urandom), txt);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_command_line();
    logic [7:0] line[$];
    int         pick;
    int         pos;
    pick = $urandom_range(9);
    repeat ($urandom_range(2)) line.push_back(CHR_SPACE);
    if (pick < 6 || pick == 8) begin
      pos = line.size();
      for (int i = 0; i < 4; i++) line.push_back(command_words[pick % 6][i]);
      if (pick == 8) line[pos + $urandom_range(3)] = printable_byte();
    end else if (pick == 6) begin
      repeat (4) line.push_back(printable_byte());
    end else if (pick == 7) begin
      repeat ($urandom_range(1, 3)) line.push_back(printable_byte());
    end else begin
      repeat ($urandom_range(5, 8)) line.push_back(printable_byte());
    end
    foreach (line[i])
      if (line[i] >= "A" && line[i] <= "Z" && $urandom_range(1)) line[i] = line[i] + 8'd32;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) line.push_back(printable_byte());
    if ($urandom_range(7) == 0) line.insert($urandom_range(line.size()), noise_byte());
    line.push_back($urandom_range(1) ? CHR_CR : CHR_LF);
    foreach (line[i]) send_byte(line[i]);
  endtask

  task automatic write_reg(dvf_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] gain, logic [9:0] off_a, logic [9:0] off_b);
    write_reg(CFG_FILTER_GAIN, gain);
    write_reg(CFG_OFFSET_A, {6'd0, off_a});
    write_reg(CFG_OFFSET_B, {6'd0, off_b});
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_replies.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int goal;
    int pick;
    bit hold_done;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FILTER_GAIN;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_SAMPLE;
    in_ch.channel   = CHAN_A;
    in_ch.sample    = '0;
    in_ch.text_byte = '0;
    hold_done       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(CHAN_A, 10'd1023);
    send_sample(CHAN_B, 10'd0);
    send_text("M802\n");
    send_sample(CHAN_A, 10'd0);
    send_text(" m800\r");
    send_text("M5");
    send_byte(8'hFF);
    send_text("00\n");
    send_text("  \r");
    send_text("Z\n");
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_regs(16'd65535, 10'd1023, 10'd0);
        1: program_regs(16'd0, 10'd0, 10'd1023);
        2: program_regs(GAIN_RESET, 10'($urandom), 10'($urandom));
        3: program_regs(16'($urandom), 10'($urandom), 10'($urandom));
        default: program_regs(16'($urandom), 10'd1023, 10'd1023);
      endcase
      send_idle_pct = (phase == 1) ? 57 : (phase == 3) ? 26 : 0;
      stall_pct     = (phase == 2) ? 57 : (phase == 3) ? 26 : 0;
      goal = items_sent + 250;
      while (items_sent < goal) begin
        if (phase == 4 && !hold_done && items_sent > goal - 200) begin
          start_hold = 1'b1;
          hold_done  = 1'b1;
        end
        pick = $urandom_range(19);
        if (pick < 9) begin
          repeat ($urandom_range(1, 4)) send_sample(1'($urandom), random_sample());
        end else if (pick < 17) begin
          send_command_line();
        end else if (pick < 18) begin
          repeat ($urandom_range(2)) send_byte(CHR_SPACE);
          send_byte($urandom_range(1) ? CHR_CR : CHR_LF);
        end else begin
          send_byte(noise_byte());
        end
      end
      drain();
    end

    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (sb.pending_replies.size() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.pending_replies.size()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: dual_vacuum_filter_with_command_reply.f
+incdir+rtl
rtl/dvf_pkg.sv
rtl/dvf_in_if.sv
rtl/dvf_out_if.sv
rtl/dual_vacuum_filter_with_command_reply.sv
test/tb_dual_vacuum_filter_with_command_reply.sv
